[src/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the prime sieve
// Value width, result kinds and the bit-serial link that runs between cells.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int VALUE_BITS = 16;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam logic [VALUE_BITS-1:0] MIN_PRIME = VALUE_BITS'(2);

  typedef enum logic [1:0] {
    KIND_STORED = 2'd0,
    KIND_END    = 2'd1,
    KIND_FULL   = 2'd2
  } kind_t;

  // One bit of a candidate, most significant bit first, with the item tags.
  // The tags are final on the last bit of the item.
  typedef struct packed {
    logic valid;
    logic dbit;
    logic first;
    logic last;
    logic is_end;
    logic dropped;
    logic stored;
  } pps_link_t;

endpackage

[src/pps_feeder.sv]
// ----------------------------------------------------------------------------
// pps_feeder: input stage of the prime sieve
// Holds max_value, classifies each item and serializes it into the chain.
// ----------------------------------------------------------------------------
module pps_feeder import pps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_candidate,
  input  logic                  adv,
  output pps_link_t             link_o
);

  logic [15:0]           max_r;
  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] sr_r, sr_nxt;
  logic                  end_r, end_nxt;
  logic                  last_bit;
  logic                  accept;

  assign last_bit = (cnt_r == CNT_W'(VALUE_BITS - 1));
  assign in_stall = busy_r & ~(adv & last_bit);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sr_nxt   = sr_r;
    end_nxt  = end_r;
    if (busy_r && adv) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      sr_nxt  = {sr_r[VALUE_BITS-2:0], 1'b0};
      if (last_bit) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sr_nxt   = in_candidate;
      end_nxt  = (in_candidate < MIN_PRIME) || (in_candidate > max_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= 16'hFFFF;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r  <= sr_nxt;
    end_r <= end_nxt;
  end

  always_comb begin
    link_o.valid   = busy_r;
    link_o.dbit    = sr_r[VALUE_BITS-1];
    link_o.first   = (cnt_r == '0);
    link_o.last    = last_bit;
    link_o.is_end  = end_r;
    link_o.dropped = 1'b0;
    link_o.stored  = 1'b0;
  end

endmodule

[src/pps_cell.sv]
// ----------------------------------------------------------------------------
// pps_cell: one filter cell of the prime sieve
// Computes a bit-serial remainder by its prime, or captures a survivor.
// ----------------------------------------------------------------------------
module pps_cell import pps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  pps_link_t link_i,
  output pps_link_t link_o
);

  logic                  filled_r;
  logic [VALUE_BITS-1:0] prime_r;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS:0]   sh, red;
  logic                  open_item;
  logic                  hit, take;
  pps_link_t             link_r, link_nxt;

  // Restoring remainder step. An empty cell simply accumulates the value.
  always_comb begin
    sh  = {(link_i.first ? {VALUE_BITS{1'b0}} : rem_r), link_i.dbit};
    red = (sh >= {1'b0, prime_r}) ? (sh - {1'b0, prime_r}) : sh;
    rem_nxt = filled_r ? red[VALUE_BITS-1:0] : sh[VALUE_BITS-1:0];
  end

  assign open_item = ~link_i.dropped & ~link_i.stored & ~link_i.is_end;
  assign hit       = filled_r & (rem_nxt == '0) & open_item;
  assign take      = ~filled_r & open_item;

  always_comb begin
    link_nxt = link_i;
    link_nxt.dropped = link_i.dropped | (link_i.last & hit);
    link_nxt.stored  = link_i.stored  | (link_i.last & take);
  end

  // Only the fill flag and the bit valid are reset; the data fields follow
  // the chain whenever it advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r     <= 1'b0;
      link_r.valid <= 1'b0;
    end else if (adv) begin
      link_r.valid <= link_i.valid;
      if (link_i.valid && link_i.last) begin
        if (link_i.is_end) begin
          filled_r <= 1'b0;
        end else if (take) begin
          filled_r <= 1'b1;
        end
      end
    end
    if (adv) begin
      link_r.dbit    <= link_nxt.dbit;
      link_r.first   <= link_nxt.first;
      link_r.last    <= link_nxt.last;
      link_r.is_end  <= link_nxt.is_end;
      link_r.dropped <= link_nxt.dropped;
      link_r.stored  <= link_nxt.stored;
      if (link_i.valid) begin
        rem_r <= rem_nxt;
        if (link_i.last && take) begin
          prime_r <= rem_nxt;
        end
      end
    end
  end

  assign link_o = link_r;

endmodule

[src/pps_collector.sv]
// ----------------------------------------------------------------------------
// pps_collector: output stage of the prime sieve
// Reassembles the value at the chain tail and holds the result item.
// ----------------------------------------------------------------------------
module pps_collector import pps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pps_link_t             link_i,
  output logic                  adv,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_result_value,
  output logic [1:0]            out_kind
);

  logic [VALUE_BITS-1:0] col_r;
  logic [VALUE_BITS-1:0] value;
  logic                  emit;
  kind_t                 kind;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  kind_t                 out_kind_r;

  assign value = {col_r[VALUE_BITS-2:0], link_i.dbit};
  assign emit  = link_i.valid & link_i.last & (link_i.is_end | ~link_i.dropped);
  assign adv   = ~(emit & out_valid_r & out_stall);

  always_comb begin
    priority if (link_i.is_end) begin
      kind = KIND_END;
    end else if (link_i.stored) begin
      kind = KIND_STORED;
    end else begin
      kind = KIND_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && link_i.valid) begin
      col_r <= value;
    end
    if (emit && adv) begin
      out_value_r <= value;
      out_kind_r  <= kind;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_kind         = out_kind_r;

endmodule

[src/pipelined_prime_sieve_top.sv]
// ----------------------------------------------------------------------------
// pipelined_prime_sieve_top: prime sieve built as a chain of filter cells
// Sieves a stream of candidates; each cell keeps one prime found so far.
// ----------------------------------------------------------------------------
// Usage. Candidates enter on in_valid/in_stall/in_candidate, normally 2 up to
// max_value in increasing order. max_value is written through cfg_we and
// cfg_wdata while the block is idle; it resets to 65535. A result item leaves
// on out_valid/out_stall with out_result_value and out_kind: a stored prime,
// a prime found while every cell is full, or the end of a run. A candidate
// below 2 or above max_value ends the run and empties the chain. A composite
// candidate gives no result.
// Streaming. Each item is fed into the chain one bit per cycle while the
// chain advances, most significant bit first; the feeder takes the next item
// only as the last bit of the previous one goes out. Items overlap in the
// chain, and since they never pass each other, a later item always sees the
// primes stored by earlier ones.
// Reset clears the fill flags of all cells, the feeder and the output
// register at once. When the receiver stalls while a result waits, the whole
// chain freezes only once the next result reaches the tail.
module pipelined_prime_sieve_top import pps_pkg::*; #(
  parameter int NUM_CELLS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_candidate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_result_value,
  output logic [1:0]            out_kind
);

  // The chain advances as one; only a stalled full output register stops it, once a new result reaches the tail.
  logic      adv;
  pps_link_t links [NUM_CELLS+1];

  pps_feeder u_feeder (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_candidate (in_candidate),
    .adv          (adv),
    .link_o       (links[0])
  );

  // Each cell holds at most one prime and passes one bit per cycle to its neighbor while the chain advances.
  // Cells fill in order, so the filled ones always form the head of the chain.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pps_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .link_i (links[i]),
      .link_o (links[i+1])
    );
  end

  pps_collector u_collector (
    .clk              (clk),
    .rst_n            (rst_n),
    .link_i           (links[NUM_CELLS]),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_kind         (out_kind)
  );

endmodule

[src/pps_checker.sv]
// ----------------------------------------------------------------------------
// pps_checker: port-level checks of the prime sieve
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module pps_checker import pps_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [VALUE_BITS-1:0] out_result_value,
  input logic [1:0]            out_kind
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_kind))
    else $error("stalled result changed");

  // The feeder is busy serializing right after it takes an item.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while the previous one is still fed");

  // A stored prime is never below two.
  a_stored_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STORED |-> out_result_value >= MIN_PRIME)
    else $error("stored prime below two");

  // No result right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pipelined_prime_sieve_top pps_checker u_pps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_kind         (out_kind)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the pipelined prime sieve
// Streams candidates into the filter chain. A predictor in the testbench keeps
// its own copy of the stored primes and the limit register, and every result
// item is checked against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import pps_pkg::*;

  localparam int NUM_CELLS    = 256;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 2500;     // one long receiver hold-off
  localparam int HOLD_AFTER   = 300;      // candidates accepted before it starts
  localparam int SETTLE       = 400;      // longer than an item takes to cross the chain
  localparam int CYCLE_LIMIT  = 600000;
  localparam int CALM_START   = 20000;    // window in which neither side idles
  localparam int CALM_END     = 30000;
  localparam logic [15:0] LIMIT_TOP = 16'hFFFF;

  typedef struct {
    logic [15:0] value;
    kind_t       kind;
  } sieve_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [15:0]           cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_candidate = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] out_result_value;
  logic [1:0]            out_kind;

  // Candidates waiting to be offered, and results predicted but not yet seen.
  logic [15:0]   candidate_q[$];
  sieve_result_t sieve_results_q[$];
  sieve_result_t oldest_expected;

  // The predictor's copy of the block state and of the limit register.
  logic [15:0] held_prime[NUM_CELLS];
  int          held_count = 0;
  logic [15:0] limit_value = LIMIT_TOP;

  int  cycle_cnt = 0;
  int  n_items = 0;
  int  n_stored = 0;
  int  n_full = 0;
  int  n_end = 0;
  int  n_dropped = 0;
  int  n_errors = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic calm;

  assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);

  pipelined_prime_sieve_top #(.NUM_CELLS(NUM_CELLS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_kind         (out_kind)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sieve one accepted candidate against the primes held so far. A value that
  // is out of range ends the run and empties the chain. A survivor takes the
  // next free cell, or is reported as found beyond a full chain.
  function automatic void sieve_candidate(input logic [15:0] cand);
    sieve_result_t res;
    bit            divisible;
    divisible = 1'b0;
    res.value = cand;
    if (cand < MIN_PRIME || cand > limit_value) begin
      held_count = 0;
      res.kind   = KIND_END;
      n_end++;
      sieve_results_q.push_back(res);
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (held_prime[i] != 0 && (cand % held_prime[i]) == 0) divisible = 1'b1;
      end
      if (divisible) begin
        n_dropped++;
      end else begin
        if (held_count < NUM_CELLS) begin
          held_prime[held_count] = cand;
          held_count++;
          res.kind = KIND_STORED;
          n_stored++;
        end else begin
          res.kind = KIND_FULL;
          n_full++;
        end
        sieve_results_q.push_back(res);
      end
    end
  endfunction

  // Sender. A candidate stays on the port until it is taken; only then may a
  // gap follow, so the decision to idle never looks at in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sieve_candidate(in_candidate);
        n_items = n_items + 1;
      end
      if (!in_valid || !in_stall) begin
        if (candidate_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid     <= 1'b1;
          in_candidate <= candidate_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off once the stream is well under way, counted
  // here in cycles: it lets the chain fill up and push back on the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_items >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver. Each result is compared with the oldest prediction. The stall
  // is random, except while the long hold-off runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (sieve_results_q.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d kind %0d",
                   $time, out_result_value, out_kind);
          n_errors++;
        end else begin
          oldest_expected = sieve_results_q.pop_front();
          if (out_result_value !== oldest_expected.value) begin
            $display("%0t: result value mismatch: expected %0d, actual %0d",
                     $time, oldest_expected.value, out_result_value);
            n_errors++;
          end
          if (out_kind !== oldest_expected.kind) begin
            $display("%0t: kind mismatch for value %0d: expected %0d, actual %0d",
                     $time, oldest_expected.value, oldest_expected.kind, out_kind);
            n_errors++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, sieve_results_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void offer(input logic [15:0] cand);
    candidate_q.push_back(cand);
  endfunction

  // Wait until every candidate has been taken and every predicted result has
  // arrived, then give composites still inside the chain time to fall out.
  task automatic settle();
    while (candidate_q.size() != 0 || in_valid || sieve_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called while the block is idle. The predictor follows at once, as
  // no candidate can be accepted before the register has taken the value.
  task automatic write_limit(input logic [15:0] lim);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= lim;
    limit_value = lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random stimulus up to a total number of queued candidates. Most of it is
  // well-formed runs (2 upward, closed by an out-of-range value) with a few
  // repeats, backward steps and skips mixed in; the rest is raw noise and
  // short descending sequences.
  task automatic add_random_runs(input int target, input logic [15:0] lim);
    int r;
    int len;
    int v;
    int start;
    while (candidate_q.size() + n_items < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(3, (lim < 150) ? ((lim < 3) ? 3 : int'(lim)) : 150);
        v = 2;
        for (int k = 0; k < len; k++) begin
          offer(16'(v));
          if ($urandom_range(99) < 8)
            offer(($urandom_range(1) != 0) ? 16'(v) : 16'($urandom_range(v, 2)));
          v += ($urandom_range(99) < 85) ? 1 : $urandom_range(5, 2);
        end
        if (lim < LIMIT_TOP && $urandom_range(1) != 0)
          offer(16'($urandom_range(65535, int'(lim) + 1)));
        else
          offer(16'($urandom_range(1, 0)));
      end else if (r < 90) begin
        repeat (6) offer(16'($urandom_range(65535, 0)));
      end else begin
        start = $urandom_range(400, 8);
        for (int k = 0; k < 5; k++) offer(16'(start - k * $urandom_range(3, 1)));
      end
    end
  endtask

  initial begin
    int top;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset limit: run ends on an empty chain, the first
    // primes, a composite, a repeat of a stored prime, the top code (composite),
    // the largest 16-bit prime and a lone high bit.
    offer(16'd0);
    offer(16'd1);
    offer(16'd2);
    offer(16'd3);
    offer(16'd4);
    offer(16'd5);
    offer(16'd6);
    offer(16'd7);
    offer(16'd7);
    offer(16'd9);
    offer(16'hFFFF);
    offer(16'd65521);
    offer(16'h8000);
    offer(16'd0);
    settle();

    // Smallest legal limit: only 2 is data, 3 already ends the run.
    write_limit(16'd2);
    offer(16'd2);
    offer(16'd3);
    offer(16'd2);
    offer(16'd2);
    offer(16'd1);
    settle();

    // A limit below 2 turns every candidate into the end of a run.
    write_limit(16'd0);
    offer(16'd0);
    offer(16'd2);
    offer(16'hFFFF);
    settle();

    // Full range again. The first run offers 2 and then the odd values, far
    // enough to fill all cells and then find primes beyond a full chain.
    write_limit(LIMIT_TOP);
    top = $urandom_range(1700, 1625);
    offer(16'd2);
    for (int v = 3; v <= top; v += 2) offer(16'(v));
    offer(16'($urandom_range(1, 0)));
    add_random_runs(1050, LIMIT_TOP);
    settle();

    // A mid-range limit, so that runs also end on values above it.
    write_limit(16'($urandom_range(3000, 20)));
    add_random_runs(1350, limit_value);
    settle();

    // A small limit keeps the chains short and the run ends frequent.
    write_limit(16'($urandom_range(60, 3)));
    add_random_runs(1600, limit_value);
    settle();

    $display("%0d candidates sieved: %0d primes stored, %0d beyond a full chain, %0d dropped",
             n_items, n_stored, n_full, n_dropped);
    $display("%0d run ends; limits 65535, 2, 0 and two random values; %0d mismatches",
             n_end, n_errors);
    if (n_errors == 0 && sieve_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
